// ===== rtl/assert_macros.svh =====
// Assertion helpers for the scanline merge block.
// Both macros expect a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RSM_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define RSM_ASSERT(label, prop, msg)
`define RSM_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== rtl/rsm_pkg.sv =====
package rsm_pkg;

	// Command codes of an input request.
	localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
	localparam logic [1:0] CMD_MERGE         = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] REG_EXTERIOR_FIRST  = 1'd0;
	localparam logic [CFG_IW-1:0] REG_EXTERIOR_SECOND = 1'd1;

	// Results of one merge are capped.
	localparam int RESULT_CAP = 32;
	localparam int KW = $clog2(RESULT_CAP);

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] run_x;
		logic signed [31:0] run_index;
	} rsm_req_t;

	typedef struct packed {
		logic signed [31:0] x_start;
		logic [30:0]        x_size;
		logic signed [31:0] index_first;
		logic signed [31:0] index_second;
		logic               last;
	} rsm_rsp_t;

	typedef enum logic [1:0] {
		KIND_APPEND_FIRST,
		KIND_APPEND_SECOND,
		KIND_MERGE
	} rsm_kind_t;

	typedef struct packed {
		rsm_kind_t          kind;
		logic signed [31:0] run_x;
		logic signed [31:0] run_index;
	} rsm_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_WALK
	} rsm_back_state_t;

	typedef struct packed {
		logic busy;
		logic lists_empty;
		logic load_last;
	} rsm_back_status_t;

endpackage

// ===== rtl/rle_scanline_pair_merge.sv =====
// Run-length scanline pair merge.
//
// Requests arrive on req (valid/stall): cmd 0 appends a run entry (x, index)
// to the first list, cmd 1 to the second, cmd 2 starts a merge; cmd 3 is
// dropped. Each list ends with a sentinel entry whose x closes the last run.
// A merge sends one response per common sub-interval on rsp (valid/stall),
// the final one flagged by last, after which both lists are empty again.
// The exterior codes are written through cfg_we/cfg_index/cfg_data while the
// block is idle; the user is to keep to this, as the block does not enforce it.
//
// Timing: requests enter a two-deep queue, so a new request is taken while
// the back end works or a response waits. An append is written in the back
// end as it is taken. A merge starts with a list memory read and a priming
// step; each response then takes a further list memory read followed by the
// compare-and-step.
// When rsp is stalled the walk holds with its response registered.
// Reset clears both lists and sets both exterior codes to -1.
`include "assert_macros.svh"

module rle_scanline_pair_merge #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rsm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                cfg_data,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  rsm_pkg::rsm_req_t          req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output rsm_pkg::rsm_rsp_t          rsp
);
	import rsm_pkg::*;

	logic             op_valid;
	logic             op_pop;
	rsm_op_t          op;
	rsm_back_status_t bk_status;

	// The front end classifies requests and queues them.
	rsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.op_valid  (op_valid),
		.op_pop    (op_pop),
		.op        (op)
	);

	// The back end holds the lists and walks them on a merge.
	rsm_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op_valid  (op_valid),
		.op_pop    (op_pop),
		.op        (op),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.status    (bk_status)
	);

	// The back end must only take a request that the queue actually holds.
	`RSM_ASSERT(a_pop_needs_entry, op_pop |-> op_valid, "queue popped while empty")
	// No further request is taken while a merge walk is in progress.
	`RSM_ASSERT_NEVER(a_no_pop_in_walk, bk_status.busy && op_pop, "request taken mid-merge")
	// Loading the final response of a merge must leave both lists empty.
	`RSM_ASSERT(a_clear_after_last, bk_status.load_last |=> bk_status.lists_empty,
		"lists not cleared after merge")

endmodule

// ===== rtl/rsm_front.sv =====
module rsm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rsm_pkg::rsm_req_t req,
	output logic              op_valid,
	input  logic              op_pop,
	output rsm_pkg::rsm_op_t  op
);
	import rsm_pkg::*;

	localparam int QPW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	rsm_op_t          queue_q [QUEUE_DEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             known_cmd;
	logic             push;
	rsm_kind_t        kind;

	// Unused command codes are swallowed here and never reach the back end.
	always_comb begin
		known_cmd = 1'b1;
		kind      = KIND_MERGE;
		unique case (req.cmd)
			CMD_APPEND_FIRST:  kind = KIND_APPEND_FIRST;
			CMD_APPEND_SECOND: kind = KIND_APPEND_SECOND;
			CMD_MERGE:         kind = KIND_MERGE;
			default:           known_cmd = 1'b0;
		endcase
	end

	assign req_stall = (count_q == QCW'(QUEUE_DEPTH));
	assign push      = req_valid && !req_stall && known_cmd;
	assign op_valid  = (count_q != '0);
	assign op        = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{kind: kind, run_x: req.run_x, run_index: req.run_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (op_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !op_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (!push && op_pop) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

// ===== rtl/rsm_back.sv =====
module rsm_back #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rsm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      op_valid,
	output logic                      op_pop,
	input  rsm_pkg::rsm_op_t          op,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output rsm_pkg::rsm_rsp_t         rsp,
	output rsm_pkg::rsm_back_status_t status
);
	import rsm_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	function automatic logic [31:0] smin(logic [31:0] a, logic [31:0] b);
		return ($signed(a) < $signed(b)) ? a : b;
	endfunction

	// List storage.
	logic [31:0] first_x_mem   [MAX_ENTRIES];
	logic [31:0] first_idx_mem [MAX_ENTRIES];
	logic [31:0] second_x_mem  [MAX_ENTRIES];
	logic [31:0] second_idx_mem[MAX_ENTRIES];

	logic [31:0] ext1_q, ext2_q;
	logic [CW-1:0] first_count_q, second_count_q;

	rsm_back_state_t state_q, state_d;
	logic prime_q;
	logic v1_q, v2_q;
	logic [AW-1:0] i1_q, i2_q, e1_q, e2_q;
	logic [31:0] d1_q, d2_q, xs_q, sz_q;
	logic [KW-1:0] k_q;

	// Registered read data at each cursor.
	logic [31:0] fx_cur_q, fx_nxt_q, fd_cur_q;
	logic [31:0] sx_cur_q, sx_nxt_q, sd_cur_q;

	logic rsp_valid_q;
	rsm_rsp_t rsp_q;

	logic wr_first, wr_second, out_free, walk_go, load, load_last;
	logic pv1, pv2, empty_both, done;
	logic [AW-1:0] pe1, pe2;
	logic e_v1, e_v2;
	logic [AW-1:0] e_e1, e_e2;
	logic [31:0] e_d1, e_d2, e_sz;
	logic n_v1, n_v2;
	logic [AW-1:0] n_i1, n_i2;
	logic [31:0] n_d1, n_d2, n_xs, n_sz;
	logic signed [31:0] xf, xfn, xq, xqn;

	assign xf  = $signed(fx_cur_q);
	assign xfn = $signed(fx_nxt_q);
	assign xq  = $signed(sx_cur_q);
	assign xqn = $signed(sx_nxt_q);

	// Memories: one write port, reads at cursor and cursor plus one.
	always_ff @(posedge clk) begin
		if (wr_first) begin
			first_x_mem[first_count_q[AW-1:0]]   <= op.run_x;
			first_idx_mem[first_count_q[AW-1:0]] <= op.run_index;
		end
		if (wr_second) begin
			second_x_mem[second_count_q[AW-1:0]]   <= op.run_x;
			second_idx_mem[second_count_q[AW-1:0]] <= op.run_index;
		end
		fx_cur_q <= first_x_mem[i1_q];
		fx_nxt_q <= first_x_mem[i1_q + AW'(1)];
		fd_cur_q <= first_idx_mem[i1_q];
		sx_cur_q <= second_x_mem[i2_q];
		sx_nxt_q <= second_x_mem[i2_q + AW'(1)];
		sd_cur_q <= second_idx_mem[i2_q];
	end

	// Start-of-merge view: cursors are at zero during the first walk cycle.
	assign pv1 = (first_count_q >= CW'(2)) && (fx_cur_q != fx_nxt_q);
	assign pv2 = (second_count_q >= CW'(2)) && (sx_cur_q != sx_nxt_q);
	assign pe1 = pv1 ? AW'(first_count_q - CW'(1)) : '0;
	assign pe2 = pv2 ? AW'(second_count_q - CW'(1)) : '0;
	assign empty_both = !pv1 && !pv2;

	// The first step starts from both exterior codes and a zero length, so
	// that advancing an index by the previous length leaves it unchanged.
	assign e_v1 = prime_q ? pv1 : v1_q;
	assign e_v2 = prime_q ? pv2 : v2_q;
	assign e_e1 = prime_q ? pe1 : e1_q;
	assign e_e2 = prime_q ? pe2 : e2_q;
	assign e_d1 = prime_q ? ext1_q : d1_q;
	assign e_d2 = prime_q ? ext2_q : d2_q;
	assign e_sz = prime_q ? 32'd0 : sz_q;

	// One step of the walk: pass the nearer boundary and open the next interval.
	always_comb begin
		n_v1 = e_v1;
		n_v2 = e_v2;
		n_i1 = i1_q;
		n_i2 = i2_q;
		n_d1 = e_d1;
		n_d2 = e_d2;
		n_xs = xs_q;
		n_sz = e_sz;
		if (e_v1 && e_v2) begin
			if (xf < xq) begin
				n_xs = xf;
				if (!e_d2[31]) begin
					n_d2 = e_d2 + e_sz;
				end
				if (i1_q != e_e1) begin
					n_d1 = fd_cur_q;
					n_i1 = i1_q + AW'(1);
					n_sz = smin(xq, xfn) - xf;
				end else begin
					n_d1 = ext1_q;
					n_v1 = 1'b0;
					n_sz = xq - xf;
				end
			end else if (xq < xf) begin
				n_xs = xq;
				if (!e_d1[31]) begin
					n_d1 = e_d1 + e_sz;
				end
				if (i2_q != e_e2) begin
					n_d2 = sd_cur_q;
					n_i2 = i2_q + AW'(1);
					n_sz = smin(xf, xqn) - xq;
				end else begin
					n_d2 = ext2_q;
					n_v2 = 1'b0;
					n_sz = xf - xq;
				end
			end else if (i1_q != e_e1) begin
				n_d1 = fd_cur_q;
				n_i1 = i1_q + AW'(1);
				n_xs = xf;
				if (i2_q != e_e2) begin
					n_d2 = sd_cur_q;
					n_i2 = i2_q + AW'(1);
					n_sz = smin(xfn, xqn) - xf;
				end else begin
					n_d2 = ext2_q;
					n_v2 = 1'b0;
					n_sz = xfn - xf;
				end
			end else begin
				n_d1 = ext1_q;
				n_v1 = 1'b0;
				if (i2_q != e_e2) begin
					n_d2 = sd_cur_q;
					n_i2 = i2_q + AW'(1);
					n_xs = xq;
					n_sz = xqn - xq;
				end else begin
					n_v2 = 1'b0;
				end
			end
		end else if (e_v1 && (i1_q != e_e1)) begin
			n_d1 = fd_cur_q;
			n_xs = xf;
			n_i1 = i1_q + AW'(1);
			n_sz = xfn - xf;
		end else if (e_v2 && (i2_q != e_e2)) begin
			n_d2 = sd_cur_q;
			n_xs = xq;
			n_i2 = i2_q + AW'(1);
			n_sz = xqn - xq;
		end else begin
			n_v1 = 1'b0;
			n_v2 = 1'b0;
		end
	end

	assign done = !n_v1 && !n_v2;

	// Sequencer outputs.
	always_comb begin
		out_free  = !rsp_valid_q || !rsp_stall;
		op_pop    = (state_q == BK_IDLE) && op_valid;
		wr_first  = op_pop && (op.kind == KIND_APPEND_FIRST)
			&& (first_count_q < CW'(MAX_ENTRIES));
		wr_second = op_pop && (op.kind == KIND_APPEND_SECOND)
			&& (second_count_q < CW'(MAX_ENTRIES));
		walk_go   = (state_q == BK_WALK) && out_free;
		load      = walk_go && (!prime_q || empty_both);
		load_last = load && (prime_q || done || (k_q == KW'(RESULT_CAP - 1)));
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (op_pop && (op.kind == KIND_MERGE)) begin
					state_d = BK_FETCH;
				end
			end
			BK_FETCH: state_d = BK_WALK;
			BK_WALK: begin
				if (walk_go) begin
					state_d = load_last ? BK_IDLE : BK_FETCH;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_IDLE;
			prime_q        <= 1'b0;
			v1_q           <= 1'b0;
			v2_q           <= 1'b0;
			i1_q           <= '0;
			i2_q           <= '0;
			k_q            <= '0;
			first_count_q  <= '0;
			second_count_q <= '0;
			rsp_valid_q    <= 1'b0;
			ext1_q         <= '1;
			ext2_q         <= '1;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_EXTERIOR_FIRST:  ext1_q <= cfg_data;
					REG_EXTERIOR_SECOND: ext2_q <= cfg_data;
					default: ;
				endcase
			end
			if (wr_first) begin
				first_count_q <= first_count_q + CW'(1);
			end
			if (wr_second) begin
				second_count_q <= second_count_q + CW'(1);
			end
			if (op_pop && (op.kind == KIND_MERGE)) begin
				i1_q    <= '0;
				i2_q    <= '0;
				k_q     <= '0;
				prime_q <= 1'b1;
			end
			if (walk_go) begin
				prime_q <= 1'b0;
				v1_q    <= n_v1;
				v2_q    <= n_v2;
				i1_q    <= n_i1;
				i2_q    <= n_i2;
				if (!prime_q) begin
					k_q <= k_q + KW'(1);
				end
			end
			if (load_last) begin
				first_count_q  <= '0;
				second_count_q <= '0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Walk payload and result register.
	always_ff @(posedge clk) begin
		if (walk_go) begin
			e1_q <= e_e1;
			e2_q <= e_e2;
			d1_q <= n_d1;
			d2_q <= n_d2;
			xs_q <= n_xs;
			sz_q <= n_sz;
		end
		if (load) begin
			if (prime_q) begin
				rsp_q <= '{x_start: '0, x_size: '0, index_first: ext1_q,
					index_second: ext2_q, last: 1'b1};
			end else begin
				rsp_q <= '{x_start: xs_q, x_size: sz_q[30:0], index_first: d1_q,
					index_second: d2_q, last: load_last};
			end
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign rsp                = rsp_q;
	assign status.busy        = (state_q != BK_IDLE);
	assign status.lists_empty = (first_count_q == '0) && (second_count_q == '0);
	assign status.load_last   = load_last;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import rsm_pkg::*;

	// The list depth that the block is built with here.
	localparam int LIST_DEPTH = 16;
	// The fourth command code has no meaning and must be dropped quietly.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Cycles to let pass once the last result is in, so that any append still
	// in the request queue or the back end has been absorbed.
	localparam int SETTLE_CYCLES = 16;
	// Upper bound on the wait for outstanding sub-intervals to drain.
	localparam int DRAIN_LIMIT = 20000;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BURSTS
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	rsm_req_t    req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsm_rsp_t    rsp;

	rle_scanline_pair_merge #(
		.MAX_ENTRIES(LIST_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the block's state, kept in step with accepted requests.
	logic [31:0] first_x [LIST_DEPTH];
	logic [31:0] first_index [LIST_DEPTH];
	logic [31:0] second_x [LIST_DEPTH];
	logic [31:0] second_index [LIST_DEPTH];
	int          first_count = 0;
	int          second_count = 0;
	logic [31:0] exterior_first = 32'hFFFF_FFFF;
	logic [31:0] exterior_second = 32'hFFFF_FFFF;

	// Sub-intervals predicted but not yet seen on the response channel.
	rsm_rsp_t pending_sub_intervals[$];
	int       mismatch_count = 0;
	// Requests still to go in the current burst of the sender.
	int       burst_left = 0;

	initial begin
		for (int n = 0; n < LIST_DEPTH; n++) begin
			first_x[n] = '0;
			first_index[n] = '0;
			second_x[n] = '0;
			second_index[n] = '0;
		end
	end

	// ------------------------------------------------------------------
	// Prediction of the merge
	// ------------------------------------------------------------------

	function automatic logic below(input logic [31:0] a, input logic [31:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic [31:0] earlier(input logic [31:0] a, input logic [31:0] b);
		return below(a, b) ? a : b;
	endfunction

	function automatic rsm_rsp_t sub_interval(input logic [31:0] xs, input logic [31:0] sz,
			input logic [31:0] d1, input logic [31:0] d2, input logic fin);
		rsm_rsp_t r;
		r.x_start = xs;
		r.x_size = sz[30:0];
		r.index_first = d1;
		r.index_second = d2;
		r.last = fin;
		return r;
	endfunction

	// Walks both shadow lists together, exactly as the block is meant to, and
	// queues every common sub-interval that the merge should produce.
	function automatic void predict_merge();
		logic        on1, on2;
		int          end1, end2, p1, p2;
		logic [31:0] xs, sz, d1, d2, xf, xq;
		rsm_rsp_t    walk[$];
		// A list takes part only if it has a first run of non-zero length.
		on1 = first_count >= 2 && first_x[0] != first_x[1];
		on2 = second_count >= 2 && second_x[0] != second_x[1];
		end1 = on1 ? first_count - 1 : 0;
		end2 = on2 ? second_count - 1 : 0;
		p1 = 0;
		p2 = 0;
		if (on1 && on2) begin
			xf = first_x[0];
			xq = second_x[0];
			if (below(xf, xq)) begin
				xs = xf; d1 = first_index[0]; d2 = exterior_second; p1 = 1;
				sz = earlier(xq, first_x[p1]) - xf;
			end else if (below(xq, xf)) begin
				xs = xq; d1 = exterior_first; d2 = second_index[0]; p2 = 1;
				sz = earlier(xf, second_x[p2]) - xq;
			end else begin
				xs = xf; d1 = first_index[0]; d2 = second_index[0]; p1 = 1; p2 = 1;
				sz = earlier(first_x[1], second_x[1]) - xf;
			end
		end else if (on1) begin
			xs = first_x[0]; d1 = first_index[0]; d2 = exterior_second; p1 = 1;
			sz = first_x[1] - xs;
		end else if (on2) begin
			xs = second_x[0]; d1 = exterior_first; d2 = second_index[0]; p2 = 1;
			sz = second_x[1] - xs;
		end else begin
			// Nothing to walk: a single empty sub-interval closes the merge.
			pending_sub_intervals.push_back(sub_interval('0, '0, exterior_first,
				exterior_second, 1'b1));
			return;
		end
		forever begin
			walk.push_back(sub_interval(xs, sz, d1, d2, 1'b0));
			if (on1 && on2) begin
				xf = first_x[p1];
				xq = second_x[p2];
				if (below(xf, xq)) begin
					// The first list steps; a defined index of the second runs on.
					xs = xf;
					if (!d2[31]) d2 += sz;
					if (p1 != end1) begin
						d1 = first_index[p1]; p1++;
						sz = earlier(xq, first_x[p1]) - xf;
					end else begin
						d1 = exterior_first; on1 = 1'b0;
						sz = xq - xf;
					end
				end else if (below(xq, xf)) begin
					xs = xq;
					if (!d1[31]) d1 += sz;
					if (p2 != end2) begin
						d2 = second_index[p2]; p2++;
						sz = earlier(xf, second_x[p2]) - xq;
					end else begin
						d2 = exterior_second; on2 = 1'b0;
						sz = xf - xq;
					end
				end else if (p1 != end1) begin
					// Both lists step at the same x.
					d1 = first_index[p1]; p1++;
					xs = xf;
					if (p2 != end2) begin
						d2 = second_index[p2]; p2++;
						sz = earlier(first_x[p1], second_x[p2]) - xf;
					end else begin
						d2 = exterior_second; on2 = 1'b0;
						sz = first_x[p1] - xf;
					end
				end else begin
					d1 = exterior_first; on1 = 1'b0;
					if (p2 != end2) begin
						d2 = second_index[p2]; p2++;
						xs = xq;
						sz = second_x[p2] - xq;
					end else begin
						on2 = 1'b0;
					end
				end
			end else if (on1 && p1 != end1) begin
				d1 = first_index[p1]; xs = first_x[p1]; p1++;
				sz = first_x[p1] - xs;
			end else if (on2 && p2 != end2) begin
				d2 = second_index[p2]; xs = second_x[p2]; p2++;
				sz = second_x[p2] - xs;
			end else begin
				on1 = 1'b0;
				on2 = 1'b0;
			end
			if (!on1 && !on2) break;
			// A merge that runs past the result cap is cut short.
			if (walk.size() >= RESULT_CAP) break;
		end
		walk[walk.size() - 1].last = 1'b1;
		foreach (walk[n]) pending_sub_intervals.push_back(walk[n]);
	endfunction

	function automatic void predict_request(input rsm_req_t r);
		case (r.cmd)
			CMD_APPEND_FIRST: begin
				if (first_count < LIST_DEPTH) begin
					first_x[first_count] = r.run_x;
					first_index[first_count] = r.run_index;
					first_count++;
				end
			end
			CMD_APPEND_SECOND: begin
				if (second_count < LIST_DEPTH) begin
					second_x[second_count] = r.run_x;
					second_index[second_count] = r.run_index;
					second_count++;
				end
			end
			CMD_MERGE: begin
				predict_merge();
				first_count = 0;
				second_count = 0;
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Response side: stall pattern and checking
	// ------------------------------------------------------------------

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_mode_left = 0;
	int          stall_run = 0;

	// The receiver changes its mood every so often: no stalls at all, light or
	// heavy random stalls, or occasional solid stretches of stall.
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_mode_left = $urandom_range(20, 120);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			STALL_NONE: rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_run > 0) begin
					stall_run--;
					rsp_stall <= 1'b1;
				end else if ($urandom_range(0, 5) == 0) begin
					stall_run = $urandom_range(1, 8);
					rsp_stall <= 1'b1;
				end else begin
					rsp_stall <= 1'b0;
				end
			end
		endcase
	end

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s differs, expected 'h%08h, got 'h%08h", $time, what,
				want, got);
		end
	endfunction

	// Every response taken by the receiver is held against the oldest
	// predicted sub-interval.
	always @(posedge clk) begin : check_responses
		rsm_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_sub_intervals.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: unexpected response, expected none, got 'h%h", $time, rsp);
			end else begin
				want = pending_sub_intervals.pop_front();
				check_field("x_start", want.x_start, rsp.x_start);
				check_field("x_size", {1'b0, want.x_size}, {1'b0, rsp.x_size});
				check_field("index_first", want.index_first, rsp.index_first);
				check_field("index_second", want.index_second, rsp.index_second);
				check_field("last", {31'd0, want.last}, {31'd0, rsp.last});
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Presents one request and waits for the block to take it. Requests go out
	// in bursts of random length; between bursts valid may drop for a gap.
	task automatic send_request(input logic [1:0] cmd, input logic [31:0] x,
			input logic [31:0] idx);
		int       gap;
		rsm_req_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		r.cmd = cmd;
		r.run_x = x;
		r.run_index = idx;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_request(r);
		burst_left--;
	endtask

	// Stops sending and waits until every predicted sub-interval has arrived,
	// then lets the block settle so that it is idle for a register write.
	task automatic wait_until_idle();
		int waited;
		req_valid <= 1'b0;
		burst_left = 0;
		waited = 0;
		while (pending_sub_intervals.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both exterior codes on back-to-back cycles.
	task automatic write_exterior_codes(input logic [31:0] code_first,
			input logic [31:0] code_second);
		cfg_we <= 1'b1;
		cfg_index <= REG_EXTERIOR_FIRST;
		cfg_data <= code_first;
		@(posedge clk);
		exterior_first = code_first;
		cfg_index <= REG_EXTERIOR_SECOND;
		cfg_data <= code_second;
		@(posedge clk);
		exterior_second = code_second;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_exterior_code();
		case ($urandom_range(0, 3))
			0: return 32'hFFFF_FFFF;
			1: return 32'h8000_0000;
			default: return 32'h8000_0000 | $urandom;
		endcase
	endfunction

	// Mostly a handful of runs; now and then an empty, a single-entry or a
	// full list, and sometimes more appends than the list can hold.
	function automatic int pick_run_count();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 1;
			2: return $urandom_range(16, 18);
			3: return $urandom_range(8, 15);
			default: return $urandom_range(2, 6);
		endcase
	endfunction

	// Start of a list: usually near zero so that the two lists overlap, and
	// sometimes close to either end of the coordinate range so that x wraps.
	function automatic logic [31:0] pick_base();
		logic [31:0] b;
		case ($urandom_range(0, 7))
			0: b = 32'h7FFF_FFC0 + $urandom_range(0, 32);
			1: b = 32'h8000_0000 + $urandom_range(0, 64);
			2: b = $urandom;
			default: begin
				b = $urandom_range(0, 120);
				b = b - 32'd60;
			end
		endcase
		return b;
	endfunction

	function automatic logic [31:0] pick_run_index();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = $urandom;
			1: v = -$urandom_range(1, 4);
			2: v = 32'h7FFF_FFFF - $urandom_range(0, 20);
			default: v = $urandom_range(0, 1000);
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// A first list whose first run has zero length and a second list with a
	// lone entry both count as empty, so the merge yields the single empty
	// sub-interval. The merge request carries all-ones fields, which it ignores.
	task automatic test_empty_lists();
		send_request(CMD_APPEND_FIRST, 32'd7, 32'd1);
		send_request(CMD_APPEND_FIRST, 32'd7, 32'd2);
		send_request(CMD_APPEND_SECOND, 32'd3, 32'd4);
		send_request(CMD_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// Overlapping lists at the extremes of x and of the index, with an
	// unused command in the middle of the loading.
	task automatic test_overlapping_runs();
		send_request(CMD_APPEND_FIRST, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_APPEND_SECOND, 32'd0, 32'd10);
		send_request(CMD_APPEND_FIRST, 32'hFFFF_FF9C, 32'h7FFF_FFFF);
		send_request(CMD_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(CMD_APPEND_SECOND, 32'd20, 32'h8000_0000);
		send_request(CMD_APPEND_FIRST, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(CMD_APPEND_SECOND, 32'd40, 32'd0);
		send_request(CMD_MERGE, 32'd0, 32'd0);
	endtask

	// One more append than the second list can hold; one x steps backwards.
	task automatic test_full_list();
		for (int k = 0; k <= LIST_DEPTH; k++)
			send_request(CMD_APPEND_SECOND, (k == 5) ? 32'd2 : k * 3, k * 10);
		send_request(CMD_MERGE, 32'd0, 32'd0);
	endtask

	// Loads two lists with random content, interleaving the appends, then
	// merges. The exterior codes change every so often while the block idles.
	task automatic test_random_merges(input int item_budget);
		logic [31:0] run_start [2][LIST_DEPTH + 2];
		logic [31:0] run_idx [2][LIST_DEPTH + 2];
		int          len [2];
		int          loaded [2];
		int          issued, phase_mark, side, style;
		issued = 0;
		phase_mark = 0;
		while (issued < item_budget) begin
			if (issued - phase_mark >= 150) begin
				wait_until_idle();
				write_exterior_codes(pick_exterior_code(), pick_exterior_code());
				phase_mark = issued;
			end
			for (side = 0; side < 2; side++) begin
				len[side] = pick_run_count();
				style = $urandom_range(0, 9);
				for (int k = 0; k < len[side]; k++) begin
					if (k == 0)
						run_start[side][k] = (style == 0) ? $urandom : pick_base();
					else if (style == 0)
						run_start[side][k] = $urandom;
					else if (style == 1)
						run_start[side][k] = run_start[side][k - 1] + $urandom_range(0, 2);
					else
						run_start[side][k] = run_start[side][k - 1] + $urandom_range(1, 40);
					run_idx[side][k] = pick_run_index();
				end
				loaded[side] = 0;
			end
			while (loaded[0] < len[0] || loaded[1] < len[1]) begin
				if ($urandom_range(0, 29) == 0)
					send_request(CMD_UNUSED, $urandom, $urandom);
				if (loaded[0] >= len[0])
					side = 1;
				else if (loaded[1] >= len[1])
					side = 0;
				else
					side = $urandom_range(0, 1);
				send_request((side == 1) ? CMD_APPEND_SECOND : CMD_APPEND_FIRST,
					run_start[side][loaded[side]], run_idx[side][loaded[side]]);
				loaded[side]++;
			end
			send_request(CMD_MERGE, $urandom, $urandom);
			issued += len[0] + len[1] + 1;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_exterior_codes(32'h8000_0000, 32'hFFFF_FFFF);
		test_empty_lists();
		test_overlapping_runs();
		test_full_list();
		wait_until_idle();
		write_exterior_codes(32'hFFFF_FFFF, 32'h8000_0000);
		test_random_merges(410);
		wait_until_idle();
		if (pending_sub_intervals.size() != 0) begin
			mismatch_count += pending_sub_intervals.size();
			foreach (pending_sub_intervals[n])
				$display("%0t ns: sub-interval never arrived, expected 'h%h, got none",
					$time, pending_sub_intervals[n]);
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Backstop in case the block hangs.
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rsm_pkg.sv
rtl/rsm_front.sv
rtl/rsm_back.sv
rtl/rle_scanline_pair_merge.sv
dv/testbench.sv
